FILE: design/msr_pkg.sv
// Shared types, widths and constants of the multi-channel servo slew ramp.
package msr_pkg;

    localparam int CHANNELS_DEF = 12;
    localparam int IDX_W_MIN    = 4;

    localparam int CMD_W      = 2;
    localparam int VAL_W      = 10;
    localparam int TRIM_W     = 8;
    localparam int PULSE_W    = 12;
    localparam int BASE_W     = 4;
    localparam int KNEE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int ANG_W  = VAL_W + 1;
    localparam int SPAN_W = PULSE_W + 1;
    localparam int MAG_W  = (ANG_W - 1) + (SPAN_W - 1);
    localparam int Q_W    = 14;

    localparam int POS_MIN   = -512;
    localparam int POS_MAX   = 511;
    localparam int TRIM_MIN  = -128;
    localparam int TRIM_MAX  = 127;
    localparam int PULSE_TOP = 4095;

    localparam int KNEE_PERIOD = 3;
    localparam int KNEE_SLOT   = 2;

    localparam int ANGLE_SPAN  = 270;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'((64'd1 << RECIP_SHIFT) / ANGLE_SPAN);

    localparam logic [BASE_W-1:0]  BASE_STEP_RST = 4'd2;
    localparam logic [KNEE_W-1:0]  KNEE_STEP_RST = 5'd4;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd125;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd600;

    localparam int FIFO_DEPTH = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TARGET = 2'd0,
        CMD_TICK        = 2'd1,
        CMD_SET_POS     = 2'd2,
        CMD_LOAD_TRIM   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_STEP = 2'd0,
        REG_KNEE_STEP = 2'd1,
        REG_PULSE_MIN = 2'd2,
        REG_PULSE_MAX = 2'd3
    } t_reg;

    typedef struct packed {
        logic last;
        logic all_at_target;
    } t_flags;

    typedef struct packed {
        logic signed [TRIM_W-1:0] trim;
        logic signed [VAL_W-1:0]  tgt;
        logic signed [VAL_W-1:0]  pos;
    } t_ent;

endpackage

FILE: design/msr_cmd_if.sv
// Command channel: command code, channel and value per beat.
interface msr_cmd_if
    import msr_pkg::*;
#(
    parameter int IDX_W = IDX_W_MIN
);
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        channel;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, cmd, channel, value, input ready);
    modport sink   (input valid, cmd, channel, value, output ready);
endinterface

FILE: design/msr_res_if.sv
// Result channel: one servo pulse width report per beat.
interface msr_res_if
    import msr_pkg::*;
#(
    parameter int IDX_W = IDX_W_MIN
);
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        servo_index;
    logic [PULSE_W-1:0]      pulse_width;
    logic signed [VAL_W-1:0] position;
    logic                    last;
    logic                    all_at_target;

    modport source (output valid, servo_index, pulse_width, position, last, all_at_target,
                     input ready);
    modport sink   (input valid, servo_index, pulse_width, position, last, all_at_target,
                     output ready);
endinterface

FILE: design/msr_cfg_if.sv
// Configuration write channel: register index and data per beat.
interface msr_cfg_if
    import msr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/msr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module msr_ram
    import msr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/msr_pulse.sv
// Four-stage pulse width pipeline: angle times span, divide by the angle span, offset, saturate.
module msr_pulse
    import msr_pkg::*;
#(
    parameter int TAG_W = 14
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [ANG_W-1:0]  i_ang,
    input  logic signed [SPAN_W-1:0] i_span,
    input  logic [PULSE_W-1:0]       i_pmin,
    input  logic [TAG_W-1:0]         i_tag,
    input  t_flags                   i_flags,
    output logic                     o_vld,
    output logic [PULSE_W-1:0]       o_pulse,
    output logic [TAG_W-1:0]         o_tag,
    output t_flags                   o_flags
);

    localparam int PROD_W = MAG_W + RECIP_W;
    localparam int SUM_W  = Q_W + 2;

    logic [3:0]               r_vld;
    logic [TAG_W-1:0]         r_tag [4];
    t_flags                   r_flags [4];
    logic [2:0]               r_neg;
    logic [MAG_W-1:0]         r_p1_mag;
    logic [MAG_W-1:0]         r_p2_mag;
    logic [Q_W-1:0]           r_p2_q0;
    logic [Q_W-1:0]           r_p3_q;
    logic [PULSE_W-1:0]       r_pulse;

    logic [ANG_W-2:0]         ang_mag;
    logic [SPAN_W-2:0]        span_mag;
    logic [PROD_W-1:0]        recip_prod;
    logic [MAG_W-1:0]         est;
    logic [MAG_W-1:0]         rem;
    logic signed [Q_W:0]      sq;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        ang_mag    = i_ang[ANG_W-1] ? (ANG_W-1)'(-i_ang) : (ANG_W-1)'(i_ang);
        span_mag   = i_span[SPAN_W-1] ? (SPAN_W-1)'(-i_span) : (SPAN_W-1)'(i_span);
        recip_prod = PROD_W'(r_p1_mag) * PROD_W'(RECIP_MULT);
        est        = MAG_W'(r_p2_q0) * MAG_W'(ANGLE_SPAN);
        rem        = r_p2_mag - est;
        sq         = r_neg[2] ? -$signed({1'b0, r_p3_q}) : $signed({1'b0, r_p3_q});
        sum        = SUM_W'(sq) + $signed(SUM_W'(i_pmin));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0]   <= i_tag;
        r_flags[0] <= i_flags;
        for (int k = 1; k < 4; k++) begin
            r_tag[k]   <= r_tag[k-1];
            r_flags[k] <= r_flags[k-1];
        end
        r_neg    <= {r_neg[1:0], i_ang[ANG_W-1] ^ i_span[SPAN_W-1]};
        r_p1_mag <= MAG_W'(ang_mag) * MAG_W'(span_mag);
        r_p2_mag <= r_p1_mag;
        r_p2_q0  <= recip_prod[RECIP_SHIFT +: Q_W];
        r_p3_q   <= (rem >= MAG_W'(ANGLE_SPAN)) ? r_p2_q0 + 1'b1 : r_p2_q0;
        if (sum < 0) begin
            r_pulse <= '0;
        end else if (sum > $signed(SUM_W'(PULSE_TOP))) begin
            r_pulse <= PULSE_W'(PULSE_TOP);
        end else begin
            r_pulse <= PULSE_W'(sum);
        end
    end

    assign o_vld   = r_vld[3];
    assign o_pulse = r_pulse;
    assign o_tag   = r_tag[3];
    assign o_flags = r_flags[3];

endmodule

FILE: design/multi_servo_slew_ramp.sv
// Top level of the multi-channel servo slew ramp with per-channel state in one RAM.
// A tick reads, steps and writes back one channel per cycle while the result FIFO credit allows.
// Load target, load trim and set position pass through the issue and write-back states;
// such a command to an out-of-range channel is accepted and ignored. Results leave one per cycle while taken.
// Throughput is set by the single RAM read port and an 8-entry result FIFO credit.
// Reset is synchronous; entry valid bits make positions, targets and trims read as zero without a sweep.
module multi_servo_slew_ramp
    import msr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    msr_cmd_if.sink    i_cmd,
    msr_res_if.source  o_res,
    msr_cfg_if.sink    i_cfg
);

    localparam int IDX_W  = (CHANNELS > 16) ? $clog2(CHANNELS) : IDX_W_MIN;
    localparam int ADDR_W = $clog2(CHANNELS);
    localparam int PEND_W = $clog2(FIFO_DEPTH + 1);
    localparam int FPTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WB    = 3'b100
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] pos;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic [PULSE_W-1:0] pulse;
        t_flags             flags;
    } t_res;

    localparam int TAG_W = $bits(t_tag);

    t_state r_state, n_state;

    logic [BASE_W-1:0]  r_base_step;
    logic [KNEE_W-1:0]  r_knee_step;
    logic [PULSE_W-1:0] r_pulse_min;
    logic [PULSE_W-1:0] r_pulse_max;

    t_cmd                    r_cmd;
    logic [ADDR_W-1:0]       r_chan;
    logic signed [VAL_W-1:0] r_val;
    logic [ADDR_W-1:0]       r_cnt;
    logic [1:0]              r_mod3;
    logic                    r_any;
    logic                    r_done;
    logic [CHANNELS-1:0]     r_ent_vld;

    logic                    r_s1_vld;
    logic [ADDR_W-1:0]       r_s1_idx;
    logic                    r_s1_knee;
    logic                    r_s1_last;
    logic                    r_s1_ent;

    logic                     r_s2_vld;
    logic signed [ANG_W-1:0]  r_s2_ang;
    logic signed [SPAN_W-1:0] r_s2_span;
    t_tag                     r_s2_tag;
    t_flags                   r_s2_flags;

    logic [PEND_W-1:0] r_pend;
    t_res              r_fifo [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wptr;
    logic [FPTR_W-1:0] r_rptr;
    logic [PEND_W-1:0] r_fcnt;

    logic              cmd_acc;
    logic              out_acc;
    logic              is_tick;
    logic              emit_cmd;
    logic              rd_en;
    logic              last_issue;
    logic [ADDR_W-1:0] rd_addr;
    logic [$bits(t_ent)-1:0] rdata;

    t_ent                     ent;
    t_ent                     wdata;
    logic signed [ANG_W-1:0]  pos_x;
    logic signed [ANG_W-1:0]  tgt_x;
    logic signed [ANG_W-1:0]  step_x;
    logic signed [ANG_W-1:0]  diff;
    logic signed [ANG_W-1:0]  adiff;
    logic signed [ANG_W-1:0]  up;
    logic signed [ANG_W-1:0]  dn;
    logic signed [VAL_W-1:0]  newpos;
    logic signed [TRIM_W-1:0] trim_sat;
    logic                     stepped;
    logic                     any_next;
    logic                     s1_emit;
    t_flags                   s1_flags;

    logic               p_vld;
    logic [PULSE_W-1:0] p_pulse;
    logic [TAG_W-1:0]   p_tag;
    t_flags             p_flags;
    t_res               head;

    assign cmd_acc = i_cmd.valid && i_cmd.ready;
    assign out_acc = o_res.valid && o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign is_tick    = (r_cmd == CMD_TICK);
    assign emit_cmd   = is_tick || (r_cmd == CMD_SET_POS);
    assign rd_en      = (r_state == ST_ISSUE) &&
                        (!emit_cmd || (r_pend < PEND_W'(FIFO_DEPTH)));
    assign last_issue = !is_tick || (r_cnt == ADDR_W'(CHANNELS - 1));
    assign rd_addr    = is_tick ? r_cnt : r_chan;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmd_acc && ((t_cmd'(i_cmd.cmd) == CMD_TICK) ||
                                ((IDX_W+1)'(i_cmd.channel) < (IDX_W+1)'(CHANNELS)))) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (rd_en && last_issue) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base_step <= BASE_STEP_RST;
            r_knee_step <= KNEE_STEP_RST;
            r_pulse_min <= PULSE_MIN_RST;
            r_pulse_max <= PULSE_MAX_RST;
            r_done      <= 1'b1;
            r_ent_vld   <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= rd_en;
            r_s2_vld <= s1_emit;
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg'(i_cfg.index))
                    REG_BASE_STEP: r_base_step <= BASE_W'(i_cfg.data);
                    REG_KNEE_STEP: r_knee_step <= KNEE_W'(i_cfg.data);
                    REG_PULSE_MIN: r_pulse_min <= i_cfg.data;
                    REG_PULSE_MAX: r_pulse_max <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (r_s1_vld) begin
                r_ent_vld[r_s1_idx] <= 1'b1;
                if (is_tick && r_s1_last) begin
                    r_done <= !any_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_cmd  <= t_cmd'(i_cmd.cmd);
            r_chan <= i_cmd.channel[ADDR_W-1:0];
            r_val  <= i_cmd.value;
            r_cnt  <= '0;
            r_mod3 <= '0;
            r_any  <= 1'b0;
        end else begin
            if (rd_en) begin
                r_cnt  <= r_cnt + 1'b1;
                r_mod3 <= (r_mod3 == 2'(KNEE_PERIOD - 1)) ? 2'd0 : r_mod3 + 2'd1;
            end
            if (r_s1_vld && is_tick) begin
                r_any <= any_next;
            end
        end
        if (rd_en) begin
            r_s1_idx  <= rd_addr;
            r_s1_knee <= is_tick && (r_mod3 == 2'(KNEE_SLOT));
            r_s1_last <= last_issue;
            r_s1_ent  <= r_ent_vld[rd_addr];
        end
        r_s2_ang     <= ANG_W'(newpos) + ANG_W'(wdata.trim);
        r_s2_span    <= $signed({1'b0, r_pulse_max}) - $signed({1'b0, r_pulse_min});
        r_s2_tag.idx <= IDX_W'(r_s1_idx);
        r_s2_tag.pos <= newpos;
        r_s2_flags   <= s1_flags;
    end

    msr_ram #(
        .WIDTH ($bits(t_ent)),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_idx),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        ent      = r_s1_ent ? t_ent'(rdata) : '0;
        pos_x    = ANG_W'(ent.pos);
        tgt_x    = ANG_W'(ent.tgt);
        step_x   = $signed(ANG_W'(r_s1_knee ? r_knee_step : KNEE_W'(r_base_step)));
        diff     = pos_x - tgt_x;
        adiff    = (diff < 0) ? -diff : diff;
        up       = pos_x + step_x;
        dn       = pos_x - step_x;
        stepped  = 1'b0;
        newpos   = ent.pos;
        wdata    = ent;
        if (r_val < $signed(VAL_W'(TRIM_MIN))) begin
            trim_sat = TRIM_W'(TRIM_MIN);
        end else if (r_val > $signed(VAL_W'(TRIM_MAX))) begin
            trim_sat = TRIM_W'(TRIM_MAX);
        end else begin
            trim_sat = TRIM_W'(r_val);
        end
        case (r_cmd)
            CMD_TICK: begin
                if (adiff < step_x) begin
                    newpos = ent.tgt;
                end else if (pos_x < tgt_x) begin
                    stepped = 1'b1;
                    newpos  = (up > $signed(ANG_W'(POS_MAX))) ? VAL_W'(POS_MAX) : VAL_W'(up);
                end else if (pos_x > tgt_x) begin
                    stepped = 1'b1;
                    newpos  = (dn < $signed(ANG_W'(POS_MIN))) ? VAL_W'(POS_MIN) : VAL_W'(dn);
                end
                wdata.pos = newpos;
            end
            CMD_SET_POS: begin
                newpos    = r_val;
                wdata.pos = r_val;
            end
            CMD_LOAD_TARGET: begin
                wdata.tgt = r_val;
            end
            CMD_LOAD_TRIM: begin
                wdata.trim = trim_sat;
            end
            default: begin
            end
        endcase
        any_next = r_any || stepped;
        s1_emit  = r_s1_vld && emit_cmd;
        s1_flags.last          = r_s1_last;
        s1_flags.all_at_target = is_tick ? (r_s1_last && !any_next) : r_done;
    end

    msr_pulse #(
        .TAG_W (TAG_W)
    ) u_pulse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_ang   (r_s2_ang),
        .i_span  (r_s2_span),
        .i_pmin  (r_pulse_min),
        .i_tag   (r_s2_tag),
        .i_flags (r_s2_flags),
        .o_vld   (p_vld),
        .o_pulse (p_pulse),
        .o_tag   (p_tag),
        .o_flags (p_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_fcnt <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_pend <= r_pend + PEND_W'(rd_en && emit_cmd) - PEND_W'(out_acc);
            r_fcnt <= r_fcnt + PEND_W'(p_vld) - PEND_W'(out_acc);
            if (p_vld) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (out_acc) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_vld) begin
            r_fifo[r_wptr] <= '{tag: t_tag'(p_tag), pulse: p_pulse, flags: p_flags};
        end
    end

    assign head                = r_fifo[r_rptr];
    assign o_res.valid         = (r_fcnt != '0);
    assign o_res.servo_index   = head.tag.idx;
    assign o_res.pulse_width   = head.pulse;
    assign o_res.position      = head.tag.pos;
    assign o_res.last          = head.flags.last;
    assign o_res.all_at_target = head.flags.all_at_target;

    a_no_accept_during_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |-> !r_s1_vld)
        else $error("Command beat accepted while a write-back is pending.");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(FIFO_DEPTH) && r_fcnt <= r_pend)
        else $error("Outstanding result count out of bounds.");

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_vld |-> (r_fcnt < PEND_W'(FIFO_DEPTH)) || out_acc)
        else $error("Result FIFO written while full.");

    a_all_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.all_at_target |-> o_res.last)
        else $error("All-at-target flag on a beat that is not the last one.");

endmodule
